// File: rtl/core/lbc_pkg.sv
// Shared types and constants of the luminosity blend composite unit.
// No dependencies.
`default_nettype none

package lbc_pkg;

  localparam int unsigned WeightBits = 17;
  localparam int unsigned OpaBits    = 16;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned LumaShift  = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_OPACITY      = 2'd0,
    REG_WEIGHT_RED   = 2'd1,
    REG_WEIGHT_GREEN = 2'd2,
    REG_WEIGHT_BLUE  = 2'd3
  } reg_idx_e;

  localparam logic [OpaBits-1:0]    OPA_FULL           = 16'hFFFF;
  localparam logic [OpaBits-1:0]    OPA_HALF           = 16'h7FFF;
  localparam logic [WeightBits-1:0] WEIGHT_RED_RESET   = 17'd13933;
  localparam logic [WeightBits-1:0] WEIGHT_GREEN_RESET = 17'd46871;
  localparam logic [WeightBits-1:0] WEIGHT_BLUE_RESET  = 17'd4732;
  localparam logic [WeightBits-1:0] LUMA_ROUND         = 17'd32768;

endpackage

`default_nettype wire

// File: rtl/core/lbc_div.sv
// Pipelined restoring divider, one quotient bit per register stage, lanes share one divisor.
// Carries a sideband word alongside. Depends on nothing.
`default_nettype none

module lbc_div #(
  parameter int unsigned NL     = 3,
  parameter int unsigned NUM_W  = 36,
  parameter int unsigned DEN_W  = 19,
  parameter int unsigned Q_W    = 16,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [NL-1:0][NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]            den_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        out_valid_o,
  output logic [NL-1:0][Q_W-1:0]      quot_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int unsigned CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  typedef logic [NL-1:0][NUM_W-1:0] rem_t;
  typedef logic [NL-1:0][Q_W-1:0]   quo_t;

  rem_t              rem_q [Q_W];
  rem_t              rem_d [Q_W];
  quo_t              quo_q [Q_W];
  quo_t              quo_d [Q_W];
  logic [DEN_W-1:0]  den_q [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];
  logic [Q_W-1:0]    vld_q;

  always_comb begin
    rem_t             rem_src;
    quo_t             quo_src;
    logic [DEN_W-1:0] den_src;
    logic [CW-1:0]    dsh;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        rem_src = num_i;
        quo_src = '0;
        den_src = den_i;
      end else begin
        rem_src = rem_q[k-1];
        quo_src = quo_q[k-1];
        den_src = den_q[k-1];
      end
      dsh      = CW'(den_src) << (Q_W - 1 - k);
      rem_d[k] = rem_src;
      quo_d[k] = quo_src;
      for (int l = 0; l < NL; l++) begin
        if (CW'(rem_src[l]) >= dsh) begin
          rem_d[k][l]              = NUM_W'(CW'(rem_src[l]) - dsh);
          quo_d[k][l][Q_W - 1 - k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Q_W-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Q_W; k++) begin
      rem_q[k] <= rem_d[k];
      quo_q[k] <= quo_d[k];
      if (k == 0) begin
        den_q[k]  <= den_i;
        side_q[k] <= side_i;
      end else begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid_o = vld_q[Q_W-1];
  assign quot_o      = quo_q[Q_W-1];
  assign side_o      = side_q[Q_W-1];

endmodule

`default_nettype wire

// File: rtl/core/luminance_blend_composite_unit.sv
// Luminosity blend composite: top level, register file and pipeline stages.
// Depends on lbc_pkg and lbc_div.
//
// Takes one pixel per clock whenever start_i is high; busy_o stays low. Each pixel's result
// is on the result ports with done_o high for one cycle, in order. The pipeline holds two
// bit-per-stage dividers (luminance ratio and alpha blend), each CHANNEL_BITS stages deep,
// plus thirteen stages of multiply, constant divide and blend. Results cannot be held off.
// Write configuration only while no pixel is in flight.
`default_nettype none

module luminance_blend_composite_unit #(
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lbc_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [lbc_pkg::WeightBits-1:0]      cfg_data_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [CHANNEL_BITS-1:0]             base_red_i,
  input  logic [CHANNEL_BITS-1:0]             base_green_i,
  input  logic [CHANNEL_BITS-1:0]             base_blue_i,
  input  logic [CHANNEL_BITS-1:0]             base_alpha_i,
  input  logic [CHANNEL_BITS-1:0]             layer_red_i,
  input  logic [CHANNEL_BITS-1:0]             layer_green_i,
  input  logic [CHANNEL_BITS-1:0]             layer_blue_i,
  input  logic [CHANNEL_BITS-1:0]             layer_alpha_i,
  input  logic [CHANNEL_BITS-1:0]             mask_value_i,
  input  logic                                span_end_i,
  output logic                                done_o,
  output logic [CHANNEL_BITS-1:0]             result_red_o,
  output logic [CHANNEL_BITS-1:0]             result_green_o,
  output logic [CHANNEL_BITS-1:0]             result_blue_o,
  output logic [CHANNEL_BITS-1:0]             result_alpha_o,
  output logic                                span_end_out_o
);

  localparam int unsigned C    = CHANNEL_BITS;
  localparam int unsigned WB   = lbc_pkg::WeightBits;
  localparam int unsigned OB   = lbc_pkg::OpaBits;
  localparam int unsigned PW   = C + WB;
  localparam int unsigned SUMW = PW + 2;
  localparam int unsigned YW   = C + 3;
  localparam int unsigned APW  = C + OB;
  localparam int unsigned TYW  = APW + 1;
  localparam int unsigned TQW  = TYW + 1 - OB;
  localparam int unsigned CYLW = 2 * C + 3;
  localparam int unsigned N1W  = 2 * C + 4;
  localparam int unsigned CYW  = 2 * C;
  localparam int unsigned CSW  = 2 * C + 1;
  localparam int unsigned CQW  = C + 1;
  localparam int unsigned N2W  = 2 * C + 1;

  localparam logic [C-1:0] FULL      = {C{1'b1}};
  localparam logic [C-1:0] HALF_FULL = FULL >> 1;

  typedef struct packed {
    logic [2:0][C-1:0] bc;
    logic [C-1:0]      ba;
    logic              span;
  } pix_t;

  typedef struct packed {
    logic [2:0][N1W-1:0] n1;
    logic [2:0]          sat;
    logic                ybz;
    logic [YW-1:0]       yb;
  } lum_t;

  typedef struct packed {
    pix_t         pix;
    logic [C-1:0] comp;
    logic [C-1:0] newa;
    logic [2:0]   sat;
    logic         ybz;
  } side1_t;

  typedef struct packed {
    pix_t pix;
    logic pass;
  } side2_t;

  // configuration registers
  logic [OB-1:0]         opacity_q;
  logic [2:0][WB-1:0]    wt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= lbc_pkg::OPA_FULL;
      wt_q[0]   <= lbc_pkg::WEIGHT_RED_RESET;
      wt_q[1]   <= lbc_pkg::WEIGHT_GREEN_RESET;
      wt_q[2]   <= lbc_pkg::WEIGHT_BLUE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbc_pkg::REG_OPACITY:      opacity_q <= cfg_data_i[OB-1:0];
        lbc_pkg::REG_WEIGHT_RED:   wt_q[0]   <= cfg_data_i;
        lbc_pkg::REG_WEIGHT_GREEN: wt_q[1]   <= cfg_data_i;
        lbc_pkg::REG_WEIGHT_BLUE:  wt_q[2]   <= cfg_data_i;
        default:                   opacity_q <= opacity_q;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // valid bits
  logic [10:1] v_q;
  logic        va_q, vb_q, done_q;
  logic        d1_v, d2_v;

  // stage 1: input register
  pix_t              s1_pix_q;
  logic [2:0][C-1:0] s1_lc_q;
  logic [C-1:0]      s1_la_q, s1_mask_q;
  // stage 2: products
  pix_t               s2_pix_q;
  logic [2:0][PW-1:0] s2_pb_q, s2_pl_q;
  logic [APW-1:0]     s2_ap_q;
  logic [C-1:0]       s2_mask_q;
  // stage 3: luminance, alpha estimate
  pix_t           s3_pix_q;
  logic [YW-1:0]  s3_yb_q, s3_yl_q;
  logic [TYW-1:0] s3_ty_q;
  logic [TQW-1:0] s3_tq_q;
  logic [C-1:0]   s3_mask_q;
  // stage 4
  pix_t                 s4_pix_q;
  logic [YW-1:0]        s4_yb_q;
  logic [2:0][CYLW-1:0] s4_cy_q;
  logic [C-1:0]         s4_t_q, s4_mask_q;
  // stage 5..10
  pix_t           s5_pix_q, s6_pix_q, s7_pix_q, s8_pix_q, s9_pix_q, s10_pix_q;
  lum_t           s5_lum_q, s6_lum_q, s7_lum_q, s8_lum_q, s9_lum_q, s10_lum_q;
  logic [CYW-1:0] s5_ay_q, s6_ay_q, s8_ny_q, s9_ny_q;
  logic [CQW-1:0] s6_cq_q, s9_nq_q;
  logic [C-1:0]   s7_comp_q, s8_comp_q, s9_comp_q, s10_comp_q, s10_newa_q;

  logic [YW-1:0]       yb_d, yl_d;
  logic [TYW-1:0]      ty_d, tr_d;
  logic [TYW:0]        tsum_d;
  logic [C-1:0]        t_d, amin_d;
  lum_t                lum_d;
  logic [CSW-1:0]      csum_d, nsum_d;
  logic [CYW-1:0]      cr_d, nr_d;
  logic [C-1:0]        comp_d, newa_d;

  always_comb begin
    amin_d = (s1_pix_q.ba < s1_la_q) ? s1_pix_q.ba : s1_la_q;
    yb_d   = YW'((SUMW'(s2_pb_q[0]) + SUMW'(s2_pb_q[1]) + SUMW'(s2_pb_q[2])
                  + SUMW'(lbc_pkg::LUMA_ROUND)) >> lbc_pkg::LumaShift);
    yl_d   = YW'((SUMW'(s2_pl_q[0]) + SUMW'(s2_pl_q[1]) + SUMW'(s2_pl_q[2])
                  + SUMW'(lbc_pkg::LUMA_ROUND)) >> lbc_pkg::LumaShift);
    ty_d   = TYW'(s2_ap_q) + TYW'(lbc_pkg::OPA_HALF);
    tsum_d = (TYW+1)'(ty_d) + ((TYW+1)'(ty_d) >> OB) + ((TYW+1)'(ty_d) >> (2 * OB));
    tr_d   = TYW'(s3_ty_q - (TYW'(s3_tq_q) << OB) + TYW'(s3_tq_q));
    t_d    = C'(s3_tq_q) + C'(tr_d >= TYW'(lbc_pkg::OPA_FULL));
    for (int i = 0; i < 3; i++) begin
      lum_d.n1[i]  = N1W'(s4_cy_q[i]) + N1W'(s4_yb_q >> 1);
      lum_d.sat[i] = lum_d.n1[i] >= (N1W'(s4_yb_q) << C);
    end
    lum_d.ybz = (s4_yb_q == '0);
    lum_d.yb  = s4_yb_q;
    for (int i = 0; i < 3; i++) begin
      if (lum_d.sat[i] || lum_d.ybz) begin
        lum_d.n1[i] = '0;
      end
    end
    csum_d = (CSW'(s5_ay_q) + (CSW'(s5_ay_q) >> C)) >> C;
    cr_d   = CYW'(s6_ay_q - (CYW'(s6_cq_q) << C) + CYW'(s6_cq_q));
    comp_d = C'(s6_cq_q) + C'(cr_d >= CYW'(FULL));
    nsum_d = (CSW'(s8_ny_q) + (CSW'(s8_ny_q) >> C)) >> C;
    nr_d   = CYW'(s9_ny_q - (CYW'(s9_nq_q) << C) + CYW'(s9_nq_q));
    newa_d = s9_pix_q.ba + C'(s9_nq_q) + C'(nr_d >= CYW'(FULL));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[9:1], start_i & ~busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pix_q.bc[0] <= base_red_i;
    s1_pix_q.bc[1] <= base_green_i;
    s1_pix_q.bc[2] <= base_blue_i;
    s1_pix_q.ba    <= base_alpha_i;
    s1_pix_q.span  <= span_end_i;
    s1_lc_q[0]     <= layer_red_i;
    s1_lc_q[1]     <= layer_green_i;
    s1_lc_q[2]     <= layer_blue_i;
    s1_la_q        <= layer_alpha_i;
    s1_mask_q      <= mask_value_i;

    for (int i = 0; i < 3; i++) begin
      s2_pb_q[i] <= PW'(wt_q[i]) * PW'(s1_pix_q.bc[i]);
      s2_pl_q[i] <= PW'(wt_q[i]) * PW'(s1_lc_q[i]);
    end
    s2_ap_q   <= APW'(amin_d) * APW'(opacity_q);
    s2_pix_q  <= s1_pix_q;
    s2_mask_q <= s1_mask_q;

    s3_yb_q   <= yb_d;
    s3_yl_q   <= yl_d;
    s3_ty_q   <= ty_d;
    s3_tq_q   <= TQW'(tsum_d >> OB);
    s3_pix_q  <= s2_pix_q;
    s3_mask_q <= s2_mask_q;

    for (int i = 0; i < 3; i++) begin
      s4_cy_q[i] <= CYLW'(s3_pix_q.bc[i]) * CYLW'(s3_yl_q);
    end
    s4_t_q    <= t_d;
    s4_yb_q   <= s3_yb_q;
    s4_pix_q  <= s3_pix_q;
    s4_mask_q <= s3_mask_q;

    s5_lum_q <= lum_d;
    s5_ay_q  <= CYW'(s4_t_q) * CYW'(s4_mask_q) + CYW'(HALF_FULL);
    s5_pix_q <= s4_pix_q;

    s6_cq_q  <= CQW'(csum_d);
    s6_ay_q  <= s5_ay_q;
    s6_lum_q <= s5_lum_q;
    s6_pix_q <= s5_pix_q;

    s7_comp_q <= comp_d;
    s7_lum_q  <= s6_lum_q;
    s7_pix_q  <= s6_pix_q;

    s8_ny_q   <= CYW'(FULL - s7_pix_q.ba) * CYW'(s7_comp_q) + CYW'(HALF_FULL);
    s8_comp_q <= s7_comp_q;
    s8_lum_q  <= s7_lum_q;
    s8_pix_q  <= s7_pix_q;

    s9_nq_q   <= CQW'(nsum_d);
    s9_ny_q   <= s8_ny_q;
    s9_comp_q <= s8_comp_q;
    s9_lum_q  <= s8_lum_q;
    s9_pix_q  <= s8_pix_q;

    s10_newa_q <= newa_d;
    s10_comp_q <= s9_comp_q;
    s10_lum_q  <= s9_lum_q;
    s10_pix_q  <= s9_pix_q;
  end

  // luminance ratio divider
  side1_t            s10_side;
  side1_t            d1_side;
  logic [$bits(side1_t)-1:0] d1_side_w;
  logic [2:0][C-1:0] d1_q;

  assign s10_side.pix  = s10_pix_q;
  assign s10_side.comp = s10_comp_q;
  assign s10_side.newa = s10_newa_q;
  assign s10_side.sat  = s10_lum_q.sat;
  assign s10_side.ybz  = s10_lum_q.ybz;

  lbc_div #(
    .NL     (3),
    .NUM_W  (N1W),
    .DEN_W  (YW),
    .Q_W    (C),
    .SIDE_W ($bits(side1_t))
  ) u_luma_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_q[10]),
    .num_i       (s10_lum_q.n1),
    .den_i       (s10_lum_q.yb),
    .side_i      (s10_side),
    .out_valid_o (d1_v),
    .quot_o      (d1_q),
    .side_o      (d1_side_w)
  );

  assign d1_side = side1_t'(d1_side_w);

  // blend stages
  logic [2:0][C-1:0]   sc_d;
  logic [2:0][CYW-1:0] sa_ps_q, sa_pc_q;
  logic [C-1:0]        sa_newa_q, sb_newa_q;
  logic                sa_pass_q;
  pix_t                sa_pix_q;
  logic [2:0][N2W-1:0] sb_n2_q;
  side2_t              sb_side_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      priority if (d1_side.ybz) begin
        sc_d[i] = '0;
      end else if (d1_side.sat[i]) begin
        sc_d[i] = FULL;
      end else begin
        sc_d[i] = d1_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      va_q   <= d1_v;
      vb_q   <= va_q;
      done_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sa_ps_q[i] <= CYW'(sc_d[i]) * CYW'(d1_side.comp);
      sa_pc_q[i] <= CYW'(d1_side.pix.bc[i]) * CYW'(d1_side.newa - d1_side.comp);
    end
    sa_newa_q <= d1_side.newa;
    sa_pass_q <= (d1_side.comp == '0) || (d1_side.newa == '0);
    sa_pix_q  <= d1_side.pix;

    for (int i = 0; i < 3; i++) begin
      sb_n2_q[i] <= sa_pass_q ? '0
                    : N2W'(sa_ps_q[i]) + N2W'(sa_pc_q[i]) + N2W'(sa_newa_q >> 1);
    end
    sb_newa_q      <= sa_newa_q;
    sb_side_q.pix  <= sa_pix_q;
    sb_side_q.pass <= sa_pass_q;
  end

  // blend divider
  side2_t                    d2_side;
  logic [$bits(side2_t)-1:0] d2_side_w;
  logic [2:0][C-1:0]         d2_q;

  lbc_div #(
    .NL     (3),
    .NUM_W  (N2W),
    .DEN_W  (C),
    .Q_W    (C),
    .SIDE_W ($bits(side2_t))
  ) u_blend_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vb_q),
    .num_i       (sb_n2_q),
    .den_i       (sb_newa_q),
    .side_i      (sb_side_q),
    .out_valid_o (d2_v),
    .quot_o      (d2_q),
    .side_o      (d2_side_w)
  );

  assign d2_side = side2_t'(d2_side_w);

  // output register
  logic [2:0][C-1:0] res_q;
  logic [C-1:0]      res_alpha_q;
  logic              res_span_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      res_q[i] <= d2_side.pass ? d2_side.pix.bc[i] : d2_q[i];
    end
    res_alpha_q <= d2_side.pix.ba;
    res_span_q  <= d2_side.pix.span;
  end

  assign done_o         = done_q;
  assign result_red_o   = res_q[0];
  assign result_green_o = res_q[1];
  assign result_blue_o  = res_q[2];
  assign result_alpha_o = res_alpha_q;
  assign span_end_out_o = res_span_q;

endmodule

`default_nettype wire

// File: tb/tb_luminance_blend_composite_unit.sv
// Testbench for luminance_blend_composite_unit: directed and random pixels against a
// built-in predictor of the luminosity blend, checked by a scoreboard class.
// Depends on lbc_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_luminance_blend_composite_unit;

  localparam int unsigned CB = 16;
  localparam int unsigned WB = lbc_pkg::WeightBits;
  localparam longint unsigned FULL = 65535;
  localparam int unsigned LATENCY = 2 * CB + 13;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CB-1:0] red, green, blue, alpha;
  } pixel_t;

  typedef struct packed {
    pixel_t base, layer;
    logic [CB-1:0] mask;
    logic span_end;
  } item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lbc_pkg::CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [WB-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o, done_o, span_end_out_o;
  item_t drv = '0;
  logic [CB-1:0] result_red_o, result_green_o, result_blue_o, result_alpha_o;

  int unsigned errors = 0;
  longint unsigned cycles = 0;

  luminance_blend_composite_unit #(.CHANNEL_BITS(CB)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i, .busy_o,
    .base_red_i(drv.base.red), .base_green_i(drv.base.green),
    .base_blue_i(drv.base.blue), .base_alpha_i(drv.base.alpha),
    .layer_red_i(drv.layer.red), .layer_green_i(drv.layer.green),
    .layer_blue_i(drv.layer.blue), .layer_alpha_i(drv.layer.alpha),
    .mask_value_i(drv.mask), .span_end_i(drv.span_end), .done_o,
    .result_red_o, .result_green_o, .result_blue_o, .result_alpha_o, .span_end_out_o
  );

  task automatic report(input string what, input longint unsigned got, exp);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp, cycles);
  endtask

  class blend_scoreboard;
    longint unsigned opacity = 65535;
    longint unsigned w_red = 13933, w_green = 46871, w_blue = 4732;
    pixel_t pending_px[$];
    bit pending_end[$];

    function longint unsigned rdiv(longint unsigned num, den);
      if (den == 0) return 0;
      return (num + (den >> 1)) / den;
    endfunction

    function longint unsigned luma(pixel_t p);
      return (w_red * p.red + w_green * p.green + w_blue * p.blue + 32768) >> 16;
    endfunction

    function void note_pixel(item_t it);
      longint unsigned yb, yl, amin, t, comp, newa, c, s, r;
      longint unsigned chan[3];
      pixel_t res;
      yb = luma(it.base);
      yl = luma(it.layer);
      amin = (it.base.alpha < it.layer.alpha) ? it.base.alpha : it.layer.alpha;
      t = rdiv(amin * opacity, 65535);
      comp = rdiv(t * it.mask, FULL);
      newa = it.base.alpha + rdiv((FULL - it.base.alpha) * comp, FULL);
      for (int i = 0; i < 3; i++) begin
        c = (i == 0) ? it.base.red : (i == 1) ? it.base.green : it.base.blue;
        s = 0;
        if (yb != 0) begin
          s = rdiv(c * yl, yb);
          if (s > FULL) s = FULL;
        end
        if (comp != 0 && newa != 0 && newa >= comp) begin
          r = rdiv(s * comp + c * (newa - comp), newa);
          if (r > FULL) r = FULL;
        end else begin
          r = c;
        end
        chan[i] = r;
      end
      res.red = CB'(chan[0]);
      res.green = CB'(chan[1]);
      res.blue = CB'(chan[2]);
      res.alpha = it.base.alpha;
      pending_px.push_back(res);
      pending_end.push_back(it.span_end);
    endfunction

    task check_result(pixel_t got, bit got_end);
      pixel_t e;
      bit e_end;
      if (pending_px.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      e = pending_px.pop_front();
      e_end = pending_end.pop_front();
      if (got.red !== e.red) report("red", got.red, e.red);
      if (got.green !== e.green) report("green", got.green, e.green);
      if (got.blue !== e.blue) report("blue", got.blue, e.blue);
      if (got.alpha !== e.alpha) report("alpha", got.alpha, e.alpha);
      if (got_end !== e_end) report("span_end", got_end, e_end);
    endtask
  endclass

  blend_scoreboard sb = new();
  bit quiet_stretch = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result({result_red_o, result_green_o, result_blue_o, result_alpha_o},
                      span_end_out_o);
  end

  task automatic write_reg(input lbc_pkg::reg_idx_e idx, input longint unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= WB'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lbc_pkg::REG_OPACITY: sb.opacity = val & 16'hFFFF;
      lbc_pkg::REG_WEIGHT_RED: sb.w_red = val & 17'h1FFFF;
      lbc_pkg::REG_WEIGHT_GREEN: sb.w_green = val & 17'h1FFFF;
      lbc_pkg::REG_WEIGHT_BLUE: sb.w_blue = val & 17'h1FFFF;
      default: ;
    endcase
  endtask

  task automatic set_weights(input longint unsigned op, wr, wg, wb);
    write_reg(lbc_pkg::REG_OPACITY, op);
    write_reg(lbc_pkg::REG_WEIGHT_RED, wr);
    write_reg(lbc_pkg::REG_WEIGHT_GREEN, wg);
    write_reg(lbc_pkg::REG_WEIGHT_BLUE, wb);
  endtask

  // called at a rising edge; returns at the edge that accepts the item with start_i held
  task automatic send_pixel(input item_t it);
    while (!quiet_stretch && $urandom_range(99) < 7) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    drv <= it;
    do @(posedge clk_i); while (busy_o);
    sb.note_pixel(it);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic [CB-1:0] rnd_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return CB'($urandom_range(255));
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic item_t rnd_pixel();
    item_t it;
    it.base = {rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan()};
    it.layer = {rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan()};
    it.mask = ($urandom_range(3) == 0) ? '1 : rnd_chan();
    it.span_end = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      quiet_stretch = (i >= n / 3 && i < n / 2);
      send_pixel(rnd_pixel());
    end
    quiet_stretch = 1'b0;
  endtask

  initial begin
    item_t it;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    it = '0;
    send_pixel(it);
    it = '1;
    send_pixel(it);
    it = {64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0};
    send_pixel(it);
    it = {64'h8000_4000_2000_FFFF, 64'h1000_F000_0100_8000, 16'h0000, 1'b1};
    send_pixel(it);
    it = {64'h8000_4000_2000_0000, 64'h1000_F000_0100_8000, 16'hFFFF, 1'b0};
    send_pixel(it);
    it = {64'h1234_5678_9ABC_0001, 64'hFFFF_0000_FFFF_FFFF, 16'h8000, 1'b1};
    send_pixel(it);
    it = {64'hFFFF_FFFF_FFFF_7FFF, 64'h0001_0001_0001_FFFF, 16'hFFFF, 1'b0};
    send_pixel(it);
    drain();

    set_weights(0, 13933, 46871, 4732);
    random_phase(100);
    drain();
    set_weights(65535, 65536, 65536, 65536);
    random_phase(150);
    drain();
    // only blue weighs: a pixel without blue has zero luminance
    set_weights(32768, 0, 0, 131071);
    it = {64'hFFFF_FFFF_0000_FFFF, 64'h1000_1000_1000_FFFF, 16'hFFFF, 1'b1};
    send_pixel(it);
    random_phase(150);
    drain();
    set_weights(1, 1, 131071, 1);
    random_phase(100);
    drain();
    set_weights($urandom_range(65535), $urandom_range(131071), $urandom_range(131071),
                $urandom_range(131071));
    random_phase(150);
    drain();
    set_weights(65535, 13933, 46871, 4732);
    random_phase(550);
    drain();

    if (errors == 0 && sb.pending_px.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
